// ===== rtl/core/btc_pkg.sv =====
package btc_pkg;

  localparam int DEF_MAX_NODES = 16;
  localparam int ACT_W         = 5;
  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

  // configuration register byte addresses
  localparam logic [1:0] ADDR_ACTIVE_SIZE = 2'd0;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] src_index;
    logic [3:0] dst_index;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [15:0] row_bits;
    logic        last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic clear_all;
    logic add_rd;
    logic add_wr;
    logic k_clr;
    logic k_inc;
    logic i_clr;
    logic i_inc;
    logic piv_rd;
    logic row_rd;
    logic out_rd;
    logic out_ld;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_zero;
    logic i_last;
    logic k_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/btc_ram.sv =====
module btc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/btc_ctrl.sv =====
module btc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  input  btc_pkg::status_t  status,
  output logic              in_stall,
  output btc_pkg::cmd_t     cmd
);
  import btc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD_RD = 3'd1;
  localparam logic [2:0] ST_ADD_WR = 3'd2;
  localparam logic [2:0] ST_PIV    = 3'd3;
  localparam logic [2:0] ST_ROWS   = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_OUT_RD = 3'd6;
  localparam logic [2:0] ST_OUT_LD = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          case (in_op)
            OP_ADD: begin
              state_nxt = ST_ADD_RD;
            end
            OP_CLOSE: begin
              cmd.k_clr = 1'b1;
              cmd.i_clr = 1'b1;
              if (!status.n_zero) begin
                state_nxt = ST_PIV;
              end
            end
            OP_CLEAR: begin
              cmd.clear_all = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_RD: begin
        cmd.add_rd = 1'b1;
        state_nxt  = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_PIV: begin
        cmd.piv_rd = 1'b1;
        state_nxt  = ST_ROWS;
      end
      ST_ROWS: begin
        cmd.row_rd = 1'b1;
        cmd.i_inc  = 1'b1;
        if (status.i_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last row write lands here; next pivot read must follow it
        cmd.k_inc = 1'b1;
        cmd.i_clr = 1'b1;
        state_nxt = status.k_last ? ST_OUT_RD : ST_PIV;
      end
      ST_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_nxt  = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (status.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.i_inc  = 1'b1;
          state_nxt  = status.i_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== rtl/core/btc_dpath.sv =====
module btc_dpath #(
  parameter int MAX_NODES = btc_pkg::DEF_MAX_NODES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  btc_pkg::cmd_t             cmd,
  output btc_pkg::status_t          status,
  input  btc_pkg::in_word_t         in_word,
  input  logic [btc_pkg::ACT_W-1:0] active_size,
  input  logic                      out_stall,
  output logic                      out_valid,
  output btc_pkg::out_word_t        out_word
);
  import btc_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int EW = (CW > ACT_W) ? CW : ACT_W;

  logic [CW-1:0]        n;
  logic [MAX_NODES-1:0] cols;
  logic [MAX_NODES-1:0] dst_hot;
  logic                 edge_ok;

  logic [3:0]           src_r;
  logic [3:0]           dst_r;
  logic [IW-1:0]        k_r;
  logic [IW-1:0]        i_r;
  logic [MAX_NODES-1:0] valid_r;
  logic                 rvalid_r;
  logic                 piv_ld_r;
  logic                 wb_r;
  logic [IW-1:0]        wb_addr_r;
  logic [MAX_NODES-1:0] pivot_r;
  logic                 out_valid_r;
  out_word_t            out_word_r;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [MAX_NODES-1:0] ram_wdata;
  logic                 ram_re;
  logic [IW-1:0]        ram_raddr;
  logic [MAX_NODES-1:0] ram_rdata;
  logic [MAX_NODES-1:0] row;
  logic                 out_free;

  assign n = (EW'(active_size) > EW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(active_size);

  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      cols[j]    = (EW'(j) < EW'(n));
      dst_hot[j] = (EW'(dst_r) == EW'(j));
    end
  end

  assign edge_ok = (EW'(src_r) < EW'(n)) && (EW'(dst_r) < EW'(n));

  // rows never written since the last clear read as zero
  assign row = rvalid_r ? ram_rdata : '0;

  assign ram_re    = cmd.add_rd | cmd.piv_rd | cmd.row_rd | cmd.out_rd;
  assign ram_raddr = cmd.add_rd ? IW'(src_r) : (cmd.piv_rd ? k_r : i_r);
  assign ram_we    = (cmd.add_wr && edge_ok) || (wb_r && row[k_r]);
  assign ram_waddr = cmd.add_wr ? IW'(src_r) : wb_addr_r;
  assign ram_wdata = cmd.add_wr ? (row | dst_hot) : (row | (pivot_r & cols));

  btc_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
      piv_ld_r <= 1'b0;
      wb_r     <= 1'b0;
    end else begin
      if (cmd.clear_all) begin
        valid_r <= '0;
      end else if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rvalid_r <= valid_r[ram_raddr];
      end
      piv_ld_r <= cmd.piv_rd;
      wb_r     <= cmd.row_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      src_r <= in_word.src_index;
      dst_r <= in_word.dst_index;
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_inc) begin
      i_r <= i_r + 1'b1;
    end
    if (piv_ld_r) begin
      pivot_r <= row;
    end
    wb_addr_r <= i_r;
  end

  // output register: hold while stalled, refill when taken
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_word_r.row_index <= 4'(i_r);
      out_word_r.row_bits  <= 16'(row & cols);
      out_word_r.last      <= status.i_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign status.n_zero   = (n == '0);
  assign status.i_last   = ((CW'(i_r) + 1'b1) == n);
  assign status.k_last   = ((CW'(k_r) + 1'b1) == n);
  assign status.out_free = out_free;

`ifndef SYNTHESIS
  a_ram_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("matrix write and read hit the same row");

  a_pivot_not_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    piv_ld_r |-> !wb_r)
    else $error("pivot capture overlaps a row write-back");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten while stalled");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.piv_rd || wb_r) |-> (CW'(k_r) < n))
    else $error("pivot index beyond active size");
`endif

endmodule

// ===== rtl/core/boolean_transitive_closure.sv =====
// Channel  Ports                           Carries
// in       in_valid, in_stall, in_word     op, src_index, dst_index
// out      out_valid, out_stall, out_word  row_index, row_bits, last
// cfg      psel .. pready (APB)            active_size at byte address 0
//
// Add edge: read row, write row back. Clear: the matrix empties as the word is taken.
// Close with n active nodes: closure (per pivot: pivot read, n row reads overlapped
// with write-backs, a drain step), then each emitted row is read out and loaded into
// the output register, waiting while out_stall holds it.
// Reset empties the matrix at once via per-row valid bits; active_size is 16.
// out_stall holds the readout; a new word is taken once the readout is loaded.
module boolean_transitive_closure #(
  parameter int MAX_NODES = btc_pkg::DEF_MAX_NODES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  btc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output btc_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import btc_pkg::*;

  logic [ACT_W-1:0] active_size_r;
  logic             cfg_wr;
  cmd_t             cmd;
  status_t          status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ACTIVE_SIZE);
  assign prdata = 32'(active_size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_size_r <= ACT_RESET;
    end else if (cfg_wr) begin
      active_size_r <= pwdata[ACT_W-1:0];
    end
  end

  btc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  btc_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_word     (in_word),
    .active_size (active_size_r),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

endmodule

// ===== tb/btc_checker.sv =====
module btc_checker #(
  parameter logic [1:0] SIZE_ADDR = btc_pkg::ADDR_ACTIVE_SIZE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  btc_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  btc_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 rows_pending,
  output int                 rows_checked
);
  import btc_pkg::*;

  logic [15:0] reach [0:15];
  logic [ACT_W-1:0] size_reg;
  out_word_t rows_due [$];
  int errs;
  int checked;

  initial begin
    fail_count = 0;
    rows_pending = 0;
    rows_checked = 0;
    errs = 0;
    checked = 0;
  end

  function automatic int live_nodes(input logic [ACT_W-1:0] s);
    return (s > 16) ? 16 : int'(s);
  endfunction

  function automatic logic [15:0] col_mask(input int n);
    return (n >= 16) ? 16'hFFFF : 16'((32'd1 << n) - 32'd1);
  endfunction

  // Advance the matrix by one accepted word and queue any rows it produces.
  task automatic apply_word(input in_word_t w);
    int n;
    logic [15:0] m;
    out_word_t row;
    n = live_nodes(size_reg);
    m = col_mask(n);
    case (w.op)
      OP_ADD: begin
        if (w.src_index < n && w.dst_index < n) reach[w.src_index][w.dst_index] = 1'b1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < 16; i++) reach[i] = '0;
      end
      OP_CLOSE: begin
        // columns beyond the active size are neither read nor touched
        for (int k = 0; k < n; k++)
          for (int i = 0; i < n; i++)
            if (reach[i][k]) reach[i] = reach[i] | (reach[k] & m);
        for (int i = 0; i < n; i++) begin
          row.row_index = 4'(i);
          row.row_bits  = reach[i] & m;
          row.last      = (i == n - 1);
          rows_due.insert(rows_due.size(), row);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) reach[i] = '0;
      size_reg = ACT_RESET;
      rows_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (rows_due.size() == 0) begin
          errs++;
          $display("%0t unexpected row word: expected none, got index %0d bits %h last %b",
                   $time, out_word.row_index, out_word.row_bits, out_word.last);
        end else begin
          want = rows_due.pop_front();
          checked++;
          if (out_word.row_index !== want.row_index || out_word.row_bits !== want.row_bits ||
              out_word.last !== want.last) begin
            errs++;
            $display("%0t row mismatch: exp idx %0d bits %h last %b, got idx %0d bits %h last %b",
                     $time, want.row_index, want.row_bits, want.last,
                     out_word.row_index, out_word.row_bits, out_word.last);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == SIZE_ADDR)
        size_reg = pwdata[ACT_W-1:0];
      if (in_valid && !in_stall) apply_word(in_word);
    end
    fail_count   <= errs;
    rows_pending <= rows_due.size();
    rows_checked <= checked;
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import btc_pkg::*;

  localparam logic [1:0] SIZE_ADDR   = ADDR_ACTIVE_SIZE;
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         DRAIN       = 10;
  localparam int         TAIL_CYCLES = 40;
  localparam int         ITEM_TARGET = 370;
  localparam int         QUIET_FROM  = 320;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int rows_pending;
  int rows_checked;

  int  stall_pct;
  int  stall_left;
  bit  quiet;
  int  gap_pct;
  int  cur_size;
  int  useful;
  int  words_sent;
  int  closes;
  int  size_writes;

  boolean_transitive_closure u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  btc_checker #(.SIZE_ADDR(SIZE_ADDR)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .rows_pending (rows_pending),
    .rows_checked (rows_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

  // receiver back-pressure in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst_n && !quiet && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic issue(input logic [1:0] op, input logic [3:0] src, input logic [3:0] dst);
    if (words_sent < QUIET_FROM && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_word  <= '{op: op, src_index: src, dst_index: dst};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (op == OP_CLOSE) closes++;
  endtask

  // drop valid and wait until every queued row has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_size(input logic [4:0] v);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIZE_ADDR;
    pwdata  <= {27'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_size = v;
    size_writes++;
  endtask

  function automatic logic [4:0] pick_size(input int phase);
    int r;
    case (phase)
      0: return 5'd2;
      1: return 5'd31;
      2: return 5'd16;
      3: return 5'd0;
      4: return 5'd17;
      5: return 5'd1;
      default: begin
        r = $urandom_range(0, 99);
        if (r < 50) return 5'($urandom_range(1, 16));
        if (r < 65) return 5'($urandom_range(17, 31));
        if (r < 72) return 5'd0;
        return 5'd16;
      end
    endcase
  endfunction

  task automatic random_item();
    int n;
    int r;
    logic [3:0] s;
    logic [3:0] d;
    n = (cur_size > 16) ? 16 : cur_size;
    r = $urandom_range(0, 99);
    if (r < 68 && n > 0) begin
      s = 4'($urandom_range(0, n - 1));
      d = 4'($urandom_range(0, n - 1));
      issue(OP_ADD, s, d);
      useful++;
    end else if (r < 80) begin
      issue(OP_CLOSE, 4'($urandom), 4'($urandom));
      if (n > 0) useful++;
    end else if (r < 85) begin
      issue(OP_CLEAR, 4'($urandom), 4'($urandom));
      useful++;
    end else if (r < 93) begin
      s = 4'($urandom);
      d = 4'($urandom);
      issue(OP_ADD, s, d);
      if (s < n && d < n) useful++;
    end else begin
      issue(OP_SPARE, 4'($urandom), 4'($urandom));
    end
    quiet <= (words_sent >= QUIET_FROM);
  endtask

  initial begin
    int phase;
    int len;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    out_stall  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    stall_pct  = 0;
    stall_left = 0;
    quiet      = 1'b0;
    gap_pct    = 0;
    cur_size   = 16;
    useful     = 0;
    words_sent = 0;
    closes     = 0;
    size_writes = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner indices, a cycle, the spare op and an empty closure
    stall_pct <= 25;
    issue(OP_ADD, 4'd0, 4'd15);
    issue(OP_ADD, 4'd15, 4'd0);
    issue(OP_ADD, 4'd15, 4'd15);
    issue(OP_ADD, 4'd3, 4'd5);
    issue(OP_ADD, 4'd5, 4'd7);
    issue(OP_ADD, 4'd7, 4'd3);
    issue(OP_SPARE, 4'd15, 4'd15);
    issue(OP_CLOSE, 4'd0, 4'd0);
    issue(OP_CLEAR, 4'd15, 4'd15);
    issue(OP_CLOSE, 4'd15, 4'd15);
    // leave a bit outside a smaller active size, then bring it back into view
    issue(OP_ADD, 4'd2, 4'd12);
    write_size(5'd4);
    issue(OP_ADD, 4'd1, 4'd2);
    issue(OP_ADD, 4'd4, 4'd0);
    issue(OP_CLOSE, 4'd0, 4'd0);
    write_size(5'd16);
    issue(OP_CLOSE, 4'd0, 4'd0);
    write_size(5'd0);
    issue(OP_ADD, 4'd0, 4'd0);
    issue(OP_CLOSE, 4'd0, 4'd0);
    write_size(5'd31);
    issue(OP_ADD, 4'd14, 4'd15);
    issue(OP_CLOSE, 4'd0, 4'd0);
    write_size(5'd1);
    issue(OP_ADD, 4'd0, 4'd0);
    issue(OP_ADD, 4'd1, 4'd0);
    issue(OP_CLOSE, 4'd0, 4'd0);
    issue(OP_CLEAR, 4'd0, 4'd0);

    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      write_size(pick_size(phase));
      phase++;
      case ($urandom_range(0, 2))
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 20; stall_pct <= 15; end
        default: begin gap_pct = 50; stall_pct <= 40; end
      endcase
      len = $urandom_range(15, 40);
      for (int j = 0; j < len && words_sent < ITEM_TARGET; j++) random_item();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d words sent (%0d changing the matrix or reading it out) over %0d size settings",
             words_sent, useful, size_writes);
    $display("%0d closures, %0d rows compared", closes, rows_checked);
    if (fail_count == 0 && rows_pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
